[hdl/i2cms_pkg.sv]
// Shared types, codes and defaults of the I2C master sequence engine.
`default_nettype none
package i2cms_pkg;

  localparam int SEQ_DEPTH_DEF = 32;
  localparam int ENTRY_W       = 10;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [1:0] ST_AVAILABLE = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;

  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_START_SEND   = 3'd1;
  localparam logic [2:0] ACT_SEND         = 3'd2;
  localparam logic [2:0] ACT_RESTART_SEND = 3'd3;
  localparam logic [2:0] ACT_RECEIVE      = 3'd4;
  localparam logic [2:0] ACT_STOP         = 3'd5;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_LOAD,
    OP_REJECT,
    OP_START_ARB,
    OP_START_GO,
    OP_TX_TAKE,
    OP_ABORT,
    OP_RD_RECEIVE,
    OP_FETCH,
    OP_FINISH,
    OP_RESTART,
    OP_SEND,
    OP_SCAN_BEGIN,
    OP_SCAN_STEP,
    OP_SCAN_END,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       busy;
    logic       arb;
    logic       nack;
    logic       reading;
    logic       left_zero;
    logic       pos_lt_end;
    logic       next_lt_end;
    logic       scan_in_range;
    logic [1:0] kind;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/i2cms_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/i2cms_dp.sv]
// Datapath: captured beat, sequence store, channel registers and result registers.
`default_nettype none
module i2cms_dp #(
  parameter int SEQ_DEPTH = i2cms_pkg::SEQ_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire i2cms_pkg::dp_op_t  op,
  output i2cms_pkg::dp_stat_t     stat,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [4:0]         in_entry_index,
  input  wire logic [1:0]         in_entry_kind,
  input  wire logic [7:0]         in_entry_byte,
  input  wire logic [5:0]         in_seq_len,
  input  wire logic               in_arb_lost,
  input  wire logic               in_nack_received,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_bus_action,
  output logic [7:0]              out_tx_byte,
  output logic                    out_nack_next,
  output logic                    out_rx_valid,
  output logic [7:0]              out_rx_data,
  output logic [1:0]              out_seq_status,
  output logic                    out_rejected,
  output logic                    out_done_res
);

  localparam int AW = $clog2(SEQ_DEPTH);
  localparam int PW = $clog2(SEQ_DEPTH + 2);
  localparam int SW = PW + 1;
  localparam int LW = (PW > 6) ? PW : 6;

  // captured beat
  logic [1:0] cmd_r, cmd_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [5:0] len_r, len_nxt;
  logic       arb_r, arb_nxt;
  logic       nack_r, nack_nxt;
  logic [7:0] rxb_r, rxb_nxt;

  // channel state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] end_r, end_nxt;
  logic          mode_r, mode_nxt;
  logic [PW-1:0] left_r, left_nxt;
  logic [1:0]    status_r, status_nxt;

  // staged result
  logic [2:0] act_r, act_nxt;
  logic [7:0] tx_r, tx_nxt;
  logic       nnext_r, nnext_nxt;
  logic       rxv_r, rxv_nxt;
  logic [7:0] rxd_r, rxd_nxt;
  logic       rej_r, rej_nxt;
  logic       done_r, done_nxt;

  // output register
  logic       ovalid_r, ovalid_nxt;
  logic [2:0] oact_r, oact_nxt;
  logic [7:0] otx_r, otx_nxt;
  logic       onnext_r, onnext_nxt;
  logic       orxv_r, orxv_nxt;
  logic [7:0] orxd_r, orxd_nxt;
  logic [1:0] ostat_r, ostat_nxt;
  logic       orej_r, orej_nxt;
  logic       odone_r, odone_nxt;

  logic                       ram_we;
  logic [AW-1:0]              ram_raddr;
  logic [i2cms_pkg::ENTRY_W-1:0] ram_rdata;
  logic [SW-1:0]              scan_pos;
  logic [LW-1:0]              len_ext;
  logic [PW-1:0]              len_cl;

  i2cms_ram #(
    .WIDTH (i2cms_pkg::ENTRY_W),
    .DEPTH (SEQ_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(idx_r)),
    .wdata ({kind_r, byte_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign scan_pos = SW'(pos_r) + SW'(1) + SW'(left_r);
  assign len_ext  = LW'(len_r);

  always_comb begin
    if (len_ext == LW'(0)) begin
      len_cl = PW'(1);
    end else if (len_ext > LW'(SEQ_DEPTH)) begin
      len_cl = PW'(SEQ_DEPTH);
    end else begin
      len_cl = PW'(len_ext);
    end
  end

  assign stat.cmd           = cmd_r;
  assign stat.busy          = (status_r == i2cms_pkg::ST_BUSY);
  assign stat.arb           = arb_r;
  assign stat.nack          = nack_r;
  assign stat.reading       = mode_r;
  assign stat.left_zero     = (left_r == PW'(0));
  assign stat.pos_lt_end    = (pos_r < end_r);
  assign stat.next_lt_end   = ((SW'(pos_r) + SW'(1)) < SW'(end_r));
  assign stat.scan_in_range = (scan_pos < SW'(end_r));
  assign stat.kind          = ram_rdata[9:8];
  assign stat.out_free      = !ovalid_r || out_ready;

  always_comb begin
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    len_nxt    = len_r;
    arb_nxt    = arb_r;
    nack_nxt   = nack_r;
    rxb_nxt    = rxb_r;
    pos_nxt    = pos_r;
    end_nxt    = end_r;
    mode_nxt   = mode_r;
    left_nxt   = left_r;
    status_nxt = status_r;
    act_nxt    = act_r;
    tx_nxt     = tx_r;
    nnext_nxt  = nnext_r;
    rxv_nxt    = rxv_r;
    rxd_nxt    = rxd_r;
    rej_nxt    = rej_r;
    done_nxt   = done_r;
    ovalid_nxt = ovalid_r && !out_ready;
    oact_nxt   = oact_r;
    otx_nxt    = otx_r;
    onnext_nxt = onnext_r;
    orxv_nxt   = orxv_r;
    orxd_nxt   = orxd_r;
    ostat_nxt  = ostat_r;
    orej_nxt   = orej_r;
    odone_nxt  = odone_r;
    ram_we     = 1'b0;
    ram_raddr  = AW'(pos_r);

    unique case (op)
      i2cms_pkg::OP_NOP: begin
      end
      i2cms_pkg::OP_CAPTURE: begin
        cmd_nxt   = in_cmd;
        idx_nxt   = in_entry_index;
        kind_nxt  = in_entry_kind;
        byte_nxt  = in_entry_byte;
        len_nxt   = in_seq_len;
        arb_nxt   = in_arb_lost;
        nack_nxt  = in_nack_received;
        rxb_nxt   = in_rx_byte;
        act_nxt   = i2cms_pkg::ACT_NONE;
        tx_nxt    = 8'd0;
        nnext_nxt = 1'b0;
        rxv_nxt   = 1'b0;
        rxd_nxt   = 8'd0;
        rej_nxt   = 1'b0;
        done_nxt  = 1'b0;
      end
      i2cms_pkg::OP_LOAD: begin
        ram_we = (32'(idx_r) < SEQ_DEPTH);
      end
      i2cms_pkg::OP_REJECT: begin
        rej_nxt = 1'b1;
      end
      i2cms_pkg::OP_START_ARB: begin
        end_nxt    = len_cl;
        mode_nxt   = 1'b0;
        left_nxt   = PW'(0);
        act_nxt    = i2cms_pkg::ACT_STOP;
        status_nxt = i2cms_pkg::ST_ERROR;
      end
      i2cms_pkg::OP_START_GO: begin
        end_nxt    = len_cl;
        mode_nxt   = 1'b0;
        left_nxt   = PW'(0);
        act_nxt    = i2cms_pkg::ACT_START_SEND;
        pos_nxt    = PW'(1);
        status_nxt = i2cms_pkg::ST_BUSY;
        ram_raddr  = AW'(0);
      end
      i2cms_pkg::OP_TX_TAKE: begin
        tx_nxt = ram_rdata[7:0];
      end
      i2cms_pkg::OP_ABORT: begin
        act_nxt    = i2cms_pkg::ACT_STOP;
        status_nxt = i2cms_pkg::ST_ERROR;
      end
      i2cms_pkg::OP_RD_RECEIVE: begin
        rxv_nxt   = 1'b1;
        rxd_nxt   = rxb_r;
        act_nxt   = i2cms_pkg::ACT_RECEIVE;
        nnext_nxt = (left_r == PW'(1));
        left_nxt  = left_r - PW'(1);
        pos_nxt   = pos_r + PW'(1);
      end
      i2cms_pkg::OP_FETCH: begin
        ram_raddr = AW'(pos_r);
      end
      i2cms_pkg::OP_FINISH: begin
        rxv_nxt    = mode_r;
        rxd_nxt    = mode_r ? rxb_r : 8'd0;
        act_nxt    = i2cms_pkg::ACT_STOP;
        done_nxt   = 1'b1;
        status_nxt = i2cms_pkg::ST_AVAILABLE;
      end
      i2cms_pkg::OP_RESTART: begin
        rxv_nxt   = mode_r;
        rxd_nxt   = mode_r ? rxb_r : 8'd0;
        act_nxt   = i2cms_pkg::ACT_RESTART_SEND;
        mode_nxt  = 1'b0;
        pos_nxt   = pos_r + PW'(2);
        ram_raddr = AW'(pos_r + PW'(1));
      end
      i2cms_pkg::OP_SEND: begin
        act_nxt = i2cms_pkg::ACT_SEND;
        tx_nxt  = ram_rdata[7:0];
        pos_nxt = pos_r + PW'(1);
      end
      i2cms_pkg::OP_SCAN_BEGIN: begin
        mode_nxt  = 1'b1;
        left_nxt  = PW'(0);
        ram_raddr = AW'(pos_r + PW'(1));
      end
      i2cms_pkg::OP_SCAN_STEP: begin
        left_nxt  = left_r + PW'(1);
        ram_raddr = AW'(scan_pos + SW'(1));
      end
      i2cms_pkg::OP_SCAN_END: begin
        act_nxt   = i2cms_pkg::ACT_RECEIVE;
        nnext_nxt = (left_r == PW'(0));
        pos_nxt   = pos_r + PW'(1);
      end
      i2cms_pkg::OP_EMIT: begin
        ovalid_nxt = 1'b1;
        oact_nxt   = act_r;
        otx_nxt    = tx_r;
        onnext_nxt = nnext_r;
        orxv_nxt   = rxv_r;
        orxd_nxt   = rxd_r;
        ostat_nxt  = status_r;
        orej_nxt   = rej_r;
        odone_nxt  = done_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      end_r    <= '0;
      mode_r   <= 1'b0;
      left_r   <= '0;
      status_r <= i2cms_pkg::ST_AVAILABLE;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      end_r    <= end_nxt;
      mode_r   <= mode_nxt;
      left_r   <= left_nxt;
      status_r <= status_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    len_r    <= len_nxt;
    arb_r    <= arb_nxt;
    nack_r   <= nack_nxt;
    rxb_r    <= rxb_nxt;
    act_r    <= act_nxt;
    tx_r     <= tx_nxt;
    nnext_r  <= nnext_nxt;
    rxv_r    <= rxv_nxt;
    rxd_r    <= rxd_nxt;
    rej_r    <= rej_nxt;
    done_r   <= done_nxt;
    oact_r   <= oact_nxt;
    otx_r    <= otx_nxt;
    onnext_r <= onnext_nxt;
    orxv_r   <= orxv_nxt;
    orxd_r   <= orxd_nxt;
    ostat_r  <= ostat_nxt;
    orej_r   <= orej_nxt;
    odone_r  <= odone_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_bus_action = oact_r;
  assign out_tx_byte    = otx_r;
  assign out_nack_next  = onnext_r;
  assign out_rx_valid   = orxv_r;
  assign out_rx_data    = orxd_r;
  assign out_seq_status = ostat_r;
  assign out_rejected   = orej_r;
  assign out_done_res   = odone_r;

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status_r == i2cms_pkg::ST_BUSY |-> SW'(pos_r) <= SW'(end_r) + SW'(1))
    else $error("position ran past the end of the sequence");

  a_read_run: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r && status_r == i2cms_pkg::ST_BUSY |-> SW'(pos_r) + SW'(left_r) <= SW'(end_r))
    else $error("read run extends beyond the sequence");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    op == i2cms_pkg::OP_EMIT |-> !ovalid_r || out_ready)
    else $error("result register overwritten before it was taken");

endmodule
`default_nettype wire

[hdl/i2cms_ctrl.sv]
// Controller: sequences one beat at a time through the datapath operations.
`default_nettype none
module i2cms_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire i2cms_pkg::dp_stat_t stat,
  output i2cms_pkg::dp_op_t        op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXAMINE,
    S_SCAN,
    S_TX,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    op        = i2cms_pkg::OP_NOP;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = i2cms_pkg::OP_CAPTURE;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          i2cms_pkg::CMD_LOAD: begin
            op        = i2cms_pkg::OP_LOAD;
            state_nxt = S_IDLE;
          end
          i2cms_pkg::CMD_START: begin
            priority if (stat.busy) begin
              op        = i2cms_pkg::OP_REJECT;
              state_nxt = S_EMIT;
            end else if (stat.arb) begin
              op        = i2cms_pkg::OP_START_ARB;
              state_nxt = S_EMIT;
            end else begin
              op        = i2cms_pkg::OP_START_GO;
              state_nxt = S_TX;
            end
          end
          i2cms_pkg::CMD_EVENT: begin
            priority if (!stat.busy) begin
              state_nxt = S_IDLE;
            end else if (stat.arb) begin
              op        = i2cms_pkg::OP_ABORT;
              state_nxt = S_EMIT;
            end else if (stat.reading && !stat.left_zero) begin
              op        = i2cms_pkg::OP_RD_RECEIVE;
              state_nxt = S_EMIT;
            end else if (!stat.pos_lt_end) begin
              op        = i2cms_pkg::OP_FINISH;
              state_nxt = S_EMIT;
            end else if (!stat.reading && stat.nack) begin
              op        = i2cms_pkg::OP_ABORT;
              state_nxt = S_EMIT;
            end else begin
              op        = i2cms_pkg::OP_FETCH;
              state_nxt = S_EXAMINE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_EXAMINE: begin
        priority if (stat.kind == i2cms_pkg::KIND_RESTART) begin
          op        = i2cms_pkg::OP_RESTART;
          state_nxt = stat.next_lt_end ? S_TX : S_EMIT;
        end else if (stat.reading) begin
          op        = i2cms_pkg::OP_FINISH;
          state_nxt = S_EMIT;
        end else if (stat.kind == i2cms_pkg::KIND_READ) begin
          op        = i2cms_pkg::OP_SCAN_BEGIN;
          state_nxt = S_SCAN;
        end else begin
          op        = i2cms_pkg::OP_SEND;
          state_nxt = S_EMIT;
        end
      end
      S_SCAN: begin
        if (stat.scan_in_range && stat.kind == i2cms_pkg::KIND_READ) begin
          op = i2cms_pkg::OP_SCAN_STEP;
        end else begin
          op        = i2cms_pkg::OP_SCAN_END;
          state_nxt = S_EMIT;
        end
      end
      S_TX: begin
        op        = i2cms_pkg::OP_TX_TAKE;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          op        = i2cms_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while the first is in work");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    op == i2cms_pkg::OP_SCAN_STEP |-> stat.reading && stat.scan_in_range)
    else $error("read run scan stepped outside the sequence");

  a_emit_only_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    op == i2cms_pkg::OP_EMIT |=> in_ready)
    else $error("controller did not return to idle after a result");

endmodule
`default_nettype wire

[hdl/i2c_master_sequence_engine.sv]
// Top level of the I2C master sequence engine: controller plus datapath.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | cmd, entry, seq_len, bus event fields
//   out_    | output    | out_valid / out_ready| bus action, tx byte, rx byte, status
//
// A load and an ignored beat return straight to idle; a start and a bus event end by
// emitting a result, and an event that opens a read run first walks the store's
// read port entry by entry to find the run length.
// Synchronous active-low reset clears the channel to available; the store keeps
// no reset. A new beat is taken once the result, if any, is in the output register, which
// holds while out_ready is low.
`default_nettype none
module i2c_master_sequence_engine #(
  parameter int SEQ_DEPTH = i2cms_pkg::SEQ_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [4:0] in_entry_index,
  input  wire logic [1:0] in_entry_kind,
  input  wire logic [7:0] in_entry_byte,
  input  wire logic [5:0] in_seq_len,
  input  wire logic       in_arb_lost,
  input  wire logic       in_nack_received,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_bus_action,
  output logic [7:0]      out_tx_byte,
  output logic            out_nack_next,
  output logic            out_rx_valid,
  output logic [7:0]      out_rx_data,
  output logic [1:0]      out_seq_status,
  output logic            out_rejected,
  output logic            out_done_res
);

  i2cms_pkg::dp_op_t   op;
  i2cms_pkg::dp_stat_t stat;

  i2cms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  i2cms_dp #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .stat             (stat),
    .in_cmd           (in_cmd),
    .in_entry_index   (in_entry_index),
    .in_entry_kind    (in_entry_kind),
    .in_entry_byte    (in_entry_byte),
    .in_seq_len       (in_seq_len),
    .in_arb_lost      (in_arb_lost),
    .in_nack_received (in_nack_received),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bus_action   (out_bus_action),
    .out_tx_byte      (out_tx_byte),
    .out_nack_next    (out_nack_next),
    .out_rx_valid     (out_rx_valid),
    .out_rx_data      (out_rx_data),
    .out_seq_status   (out_seq_status),
    .out_rejected     (out_rejected),
    .out_done_res     (out_done_res)
  );

endmodule
`default_nettype wire
